// File: hdl/pmq_pkg.sv
// shared types, constants and helper functions for the partitioned multi-queue
package pmq_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int MAX_QUEUES  = 8;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int POS_W  = ADDR_W + 1;
    localparam int QSEL_W = $clog2(MAX_QUEUES);
    localparam int CFG_W  = 4;
    localparam int DATA_W = 32;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [QSEL_W-1:0] qsel_t;
    typedef logic [CFG_W-1:0]  qcount_t;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BADINDEX  = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t                   opcode;
        qsel_t                     queue_select;
        logic signed [DATA_W-1:0]  data_in;
    } cmd_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  data_out;
    } rsp_t;

    // one pointer table entry per queue
    typedef struct packed {
        pos_t head;
        pos_t tail;
        pos_t fill;
    } ptr_t;

    // queue count as used: zero acts as one, large values clamp
    function automatic qcount_t eff_queues(input qcount_t raw);
        qcount_t q;
        begin
            q = raw;
            if (q == '0)
            begin
                q = qcount_t'(1);
            end
            if (q > qcount_t'(MAX_QUEUES))
            begin
                q = qcount_t'(MAX_QUEUES);
            end
            return q;
        end
    endfunction

    // words per partition for each effective queue count
    function automatic pos_t part_size(input qcount_t q);
        pos_t p;
        begin
            unique case (q)
                4'd1:    p = pos_t'(STORE_DEPTH / 1);
                4'd2:    p = pos_t'(STORE_DEPTH / 2);
                4'd3:    p = pos_t'(STORE_DEPTH / 3);
                4'd4:    p = pos_t'(STORE_DEPTH / 4);
                4'd5:    p = pos_t'(STORE_DEPTH / 5);
                4'd6:    p = pos_t'(STORE_DEPTH / 6);
                4'd7:    p = pos_t'(STORE_DEPTH / 7);
                4'd8:    p = pos_t'(STORE_DEPTH / 8);
                default: p = pos_t'(STORE_DEPTH);
            endcase
            return p;
        end
    endfunction

endpackage

// File: hdl/pmq_word_ram.sv
// shared word store: one write port, one registered read port
module pmq_word_ram
    import pmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  addr_t                    wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  addr_t                    rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/partitioned_multi_queue.sv
// top level: several linear queues sharing one word store
// results: registered from S_LOOK after the pointer table read for an insert or error,
//   or from S_FETCH after the word store read for a good remove; a full output slot stalls both
// requests: one at a time; a new request is accepted only in S_IDLE, once the previous result
//   is registered after the pointer table read and, for a good remove, the word store read
// reset: queue count 1, every queue empty at its partition start (pointer entries marked
//   invalid by flip-flops); the word store is not cleared and needs no clearing pass
module partitioned_multi_queue
    import pmq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  qcount_t cfg_data,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output rsp_t    rsp
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_FETCH = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    qcount_t                 nq_reg;
    logic [MAX_QUEUES-1:0]   valid_reg;
    cmd_t                    cmd_reg;
    logic                    ent_valid_reg;
    ptr_t                    ptr_rd_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    ptr_t                    ptr_mem [MAX_QUEUES];

    logic                    cmd_fire, cfg_fire, out_free;
    qcount_t                 q_eff;
    pos_t                    psize, start, part_end;
    logic [2*POS_W-1:0]      start_full;
    ptr_t                    ent, ent_new;
    logic                    bad_index, ins_ok, rem_ok, look_go;
    status_t                 look_status;
    logic                    ptr_wr, store_wr, store_rd;
    logic signed [DATA_W-1:0] store_q;

    assign cfg_ready = (state_reg == S_IDLE);
    assign cmd_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // partition geometry for the addressed queue
    assign q_eff      = eff_queues(nq_reg);
    assign psize      = part_size(q_eff);
    assign start_full = (2*POS_W)'(cmd_reg.queue_select) * (2*POS_W)'(psize);
    assign start      = start_full[POS_W-1:0];
    assign part_end   = start + psize;

    // pointer entry as seen by this request; never-written entries are empty
    always_comb
    begin
        if (ent_valid_reg)
        begin
            ent = ptr_rd_reg;
        end
        else
        begin
            ent.head = start;
            ent.tail = start;
            ent.fill = '0;
        end
    end

    // decide the outcome and the updated pointers
    always_comb
    begin
        bad_index   = qcount_t'(cmd_reg.queue_select) >= q_eff;
        ins_ok      = 1'b0;
        rem_ok      = 1'b0;
        look_status = ST_OK;
        ent_new     = ent;
        priority if (bad_index)
        begin
            look_status = ST_BADINDEX;
        end
        else if (cmd_reg.opcode == OP_INSERT)
        begin
            if (ent.tail >= part_end)
            begin
                look_status = ST_OVERFLOW;
            end
            else
            begin
                ins_ok       = 1'b1;
                ent_new.tail = ent.tail + pos_t'(1);
                ent_new.fill = ent.fill + pos_t'(1);
            end
        end
        else
        begin
            if (ent.fill == '0)
            begin
                look_status = ST_UNDERFLOW;
            end
            else
            begin
                rem_ok       = 1'b1;
                ent_new.fill = ent.fill - pos_t'(1);
                if (ent.fill == pos_t'(1))
                begin
                    ent_new.head = start;
                    ent_new.tail = start;
                end
                else
                begin
                    ent_new.head = ent.head + pos_t'(1);
                end
            end
        end
    end

    // a good remove moves on to the store read; all else needs the output slot
    assign look_go  = (state_reg == S_LOOK) && (rem_ok || out_free);
    assign ptr_wr   = look_go && (ins_ok || rem_ok);
    assign store_wr = look_go && ins_ok;
    assign store_rd = look_go && rem_ok;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (look_go)
                begin
                    if (rem_ok)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next        = S_IDLE;
                        rsp_valid_next    = 1'b1;
                        rsp_next.status   = look_status;
                        rsp_next.data_out = '0;
                    end
                end
            end
            S_FETCH:
            begin
                if (out_free)
                begin
                    state_next        = S_IDLE;
                    rsp_valid_next    = 1'b1;
                    rsp_next.status   = ST_OK;
                    rsp_next.data_out = store_q;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nq_reg        <= qcount_t'(1);
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_fire)
            begin
                nq_reg    <= cfg_data;
                valid_reg <= '0;
            end
            else if (ptr_wr)
            begin
                valid_reg[cmd_reg.queue_select] <= 1'b1;
            end
        end
    end

    // request capture, pointer table read and result register
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd_fire)
        begin
            cmd_reg       <= cmd;
            ent_valid_reg <= valid_reg[cmd.queue_select];
            ptr_rd_reg    <= ptr_mem[cmd.queue_select];
        end
    end

    // pointer table write back
    always_ff @(posedge clk)
    begin
        if (ptr_wr)
        begin
            ptr_mem[cmd_reg.queue_select] <= ent_new;
        end
    end

    pmq_word_ram u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (ent.tail[ADDR_W-1:0]),
        .wr_data (cmd_reg.data_in),
        .rd_en   (store_rd),
        .rd_addr (ent.head[ADDR_W-1:0]),
        .rd_data (store_q)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
